// ===== sv/console_memory_map_with_bank_mapper_assert.svh =====
// Assertion macros for the cartridge bus decoder.
// Used by the top level only; no dependencies.
`ifndef CONSOLE_MEMORY_MAP_WITH_BANK_MAPPER_ASSERT_SVH
`define CONSOLE_MEMORY_MAP_WITH_BANK_MAPPER_ASSERT_SVH

// same-cycle implication
`define CMBM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CMBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cmbm_pkg.sv =====
// Shared types and constants for the cartridge bus decoder.
// No dependencies.
package cmbm_pkg;

   localparam logic [15:0] ADDR_PEN_STATUS = 16'h8000;
   localparam logic [15:0] ADDR_PEN_POS    = 16'hA000;
   localparam logic [15:0] ADDR_PEN_AXIS   = 16'h6000;
   localparam logic [15:0] ADDR_BANK_REG   = 16'hFFFF;
   localparam logic [15:0] ADDR_ROM_TOP    = 16'hBFFF;

   localparam logic [1:0] CSR_GB_MODE   = 2'd0;
   localparam logic [1:0] CSR_ROM_COUNT = 2'd1;
   localparam logic [1:0] CSR_ROM_MASK  = 2'd2;

   localparam logic [5:0] SLOT_TWO_RESET = 6'd2;

   typedef enum logic [1:0] {
      SRC_IMM  = 2'd0,
      SRC_SRAM = 2'd1,
      SRC_RAM  = 2'd2
   } read_src_type;

   typedef struct packed {
      logic         bank_wr;
      logic         axis_wr;
      logic         sram_wr;
      logic         ram_wr;
      read_src_type src;
      logic [7:0]   imm_data;
      logic         rom_fetch;
      logic [19:0]  rom_address;
   } decode_type;

endpackage

// ===== sv/console_memory_map_with_bank_mapper.sv =====
// Cartridge bus decoder and bank mapper: top level with SRAM and work RAM.
// Depends on cmbm_pkg, cmbm_decode and console_memory_map_with_bank_mapper_assert.svh.
// Pipeline: a request passes through the memory read stage and then the output register to the response.
// Throughput: one transaction per cycle while rsp_stall is low, set by the single port of each memory.
// Reset: a clearing pass zeroes both memories, one entry per cycle, stepping through max(SRAM_BYTES,
// RAM_BYTES) entries (8192 by default) with req_stall high; csr writes are still taken.
module console_memory_map_with_bank_mapper #(
   parameter int SRAM_BYTES    = 8192,
   parameter int RAM_BYTES     = 1024,
   parameter int ROM_ADDR_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [15:0]       req_address,
   input  logic [7:0]        req_write_data,
   input  logic              req_pen_pressed,
   input  logic signed [9:0] req_pen_x,
   input  logic signed [9:0] req_pen_y,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   output logic              rsp_rom_fetch,
   output logic [19:0]       rsp_rom_address,
   output logic              rsp_sram_touched,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [20:0]       csr_data
);

`include "console_memory_map_with_bank_mapper_assert.svh"

   localparam int SramIdxBits = $clog2(SRAM_BYTES);
   localparam int RamIdxBits  = $clog2(RAM_BYTES);
   localparam int ClearDepth  = (SRAM_BYTES > RAM_BYTES) ? SRAM_BYTES : RAM_BYTES;
   localparam int ClrBits     = $clog2(ClearDepth);

   logic [7:0] cart_sram [SRAM_BYTES];
   logic [7:0] work_ram  [RAM_BYTES];

   logic                  gb_mode_ff, gb_mode_in;
   logic [20:0]           rom_count_ff, rom_count_in;
   logic [19:0]           rom_window_ff, rom_window_in;
   logic [5:0]            slot_bank_ff, slot_bank_in;
   logic                  axis_ff, axis_in;
   logic                  sram_flag_ff, sram_flag_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [ClrBits-1:0]    clr_ff, clr_in;

   logic                  s1_valid_ff, s1_valid_in;
   cmbm_pkg::read_src_type s1_src_ff;
   logic [7:0]            s1_imm_ff;
   logic                  s1_fetch_ff;
   logic [19:0]           s1_raddr_ff;
   logic                  s1_touched_ff;
   logic [7:0]            sram_q_ff;
   logic [7:0]            ram_q_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_data_ff;
   logic                  rsp_fetch_ff;
   logic [19:0]           rsp_raddr_ff;
   logic                  rsp_touched_ff;

   cmbm_pkg::decode_type  dec;
   logic                  req_accept;
   logic                  s1_move;
   logic [SramIdxBits-1:0] sram_idx;
   logic [RamIdxBits-1:0]  ram_idx;
   logic [7:0]            s1_rdata;

   cmbm_decode #(
      .ROM_ADDR_BITS(ROM_ADDR_BITS)
   ) u_decode (
      .op              (req_op),
      .address         (req_address),
      .pen_pressed     (req_pen_pressed),
      .pen_x           (req_pen_x),
      .pen_y           (req_pen_y),
      .gb_mode         (gb_mode_ff),
      .rom_byte_count  (rom_count_ff),
      .rom_address_mask(rom_window_ff),
      .slot_two_bank   (slot_bank_ff),
      .pen_axis_select (axis_ff),
      .decode          (dec)
   );

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clr_busy_ff || (s1_valid_ff && !s1_move);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign sram_idx   = req_address[SramIdxBits-1:0];
   assign ram_idx    = req_address[RamIdxBits-1:0];

   always_comb begin
      gb_mode_in    = gb_mode_ff;
      rom_count_in  = rom_count_ff;
      rom_window_in = rom_window_ff;
      if (csr_valid) begin
         unique case (csr_index)
            cmbm_pkg::CSR_GB_MODE:   gb_mode_in    = csr_data[0];
            cmbm_pkg::CSR_ROM_COUNT: rom_count_in  = csr_data;
            cmbm_pkg::CSR_ROM_MASK:  rom_window_in = csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      slot_bank_in = slot_bank_ff;
      axis_in      = axis_ff;
      sram_flag_in = sram_flag_ff;
      if (req_accept) begin
         if (dec.bank_wr) slot_bank_in = req_write_data[5:0];
         if (dec.axis_wr) axis_in = req_write_data[0];
         if (dec.sram_wr) sram_flag_in = 1'b1;
      end
   end

   always_comb begin
      clr_in      = clr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == ClrBits'(ClearDepth - 1)) clr_busy_in = 1'b0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      case (s1_src_ff)
         cmbm_pkg::SRC_SRAM: s1_rdata = sram_q_ff;
         cmbm_pkg::SRC_RAM:  s1_rdata = ram_q_ff;
         default:            s1_rdata = s1_imm_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gb_mode_ff    <= 1'b0;
         rom_count_ff  <= 21'd0;
         rom_window_ff <= 20'd0;
         slot_bank_ff  <= cmbm_pkg::SLOT_TWO_RESET;
         axis_ff       <= 1'b0;
         sram_flag_ff  <= 1'b0;
         clr_busy_ff   <= 1'b1;
         clr_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gb_mode_ff    <= gb_mode_in;
         rom_count_ff  <= rom_count_in;
         rom_window_ff <= rom_window_in;
         slot_bank_ff  <= slot_bank_in;
         axis_ff       <= axis_in;
         sram_flag_ff  <= sram_flag_in;
         clr_busy_ff   <= clr_busy_in;
         clr_ff        <= clr_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_src_ff     <= dec.src;
         s1_imm_ff     <= dec.imm_data;
         s1_fetch_ff   <= dec.rom_fetch;
         s1_raddr_ff   <= dec.rom_address;
         s1_touched_ff <= sram_flag_in;
      end
      if (s1_move) begin
         rsp_data_ff    <= s1_rdata;
         rsp_fetch_ff   <= s1_fetch_ff;
         rsp_raddr_ff   <= s1_raddr_ff;
         rsp_touched_ff <= s1_touched_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         cart_sram[clr_ff[SramIdxBits-1:0]] <= 8'h00;
      end else if (req_accept && dec.sram_wr) begin
         cart_sram[sram_idx] <= req_write_data;
      end
      if (req_accept) begin
         sram_q_ff <= cart_sram[sram_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         work_ram[clr_ff[RamIdxBits-1:0]] <= 8'h00;
      end else if (req_accept && dec.ram_wr) begin
         work_ram[ram_idx] <= req_write_data;
      end
      if (req_accept) begin
         ram_q_ff <= work_ram[ram_idx];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_rom_fetch    = rsp_fetch_ff;
   assign rsp_rom_address  = rsp_raddr_ff;
   assign rsp_sram_touched = rsp_touched_ff;

   `CMBM_ASSERT_NOW(a_clear_blocks_req, clock, reset, clr_busy_ff, req_stall, "request taken during memory clear")
   `CMBM_ASSERT_NEXT(a_sram_flag_sticky, clock, reset, sram_flag_ff, sram_flag_ff, "SRAM written flag cleared")
   `CMBM_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && rsp_valid_ff && rsp_stall, s1_valid_ff, "pipeline stage lost a transaction under stall")
   `CMBM_ASSERT_NOW(a_fetch_zero_data, clock, reset, rsp_valid_ff && rsp_fetch_ff, rsp_data_ff == 8'h00, "ROM fetch with nonzero read data")

endmodule

// ===== sv/cmbm_decode.sv =====
// Address decode for one CPU memory transaction: pen registers, ROM banking,
// SRAM/RAM selection. Depends on cmbm_pkg.
module cmbm_decode #(
   parameter int ROM_ADDR_BITS = 20
) (
   input  logic                    op,
   input  logic [15:0]             address,
   input  logic                    pen_pressed,
   input  logic signed [9:0]       pen_x,
   input  logic signed [9:0]       pen_y,
   input  logic                    gb_mode,
   input  logic [20:0]             rom_byte_count,
   input  logic [19:0]             rom_address_mask,
   input  logic [5:0]              slot_two_bank,
   input  logic                    pen_axis_select,
   output cmbm_pkg::decode_type    decode
);

   localparam logic [19:0] RomWidthMask =
      (ROM_ADDR_BITS >= 20) ? 20'hFFFFF : 20'((1 << ROM_ADDR_BITS) - 1);

   logic        in_sram;
   logic        in_ram;
   logic        rom_hit;
   logic        pen_off;
   logic [9:0]  px_adj;
   logic [9:0]  py_adj;
   logic [5:0]  bank;
   logic [19:0] phys;

   assign in_sram = (address[15:14] == 2'b10);
   assign in_ram  = (address[15:14] == 2'b11);
   assign rom_hit = (address <= cmbm_pkg::ADDR_ROM_TOP) &&
                    ({5'd0, address} < rom_byte_count);
   assign pen_off = (pen_x < 10'sd2) || (pen_x > 10'sd254) ||
                    (pen_y < 10'sd0) || (pen_y > 10'sd192);
   assign px_adj  = pen_x - 10'sd2;
   assign py_adj  = pen_y + 10'sd28;

   always_comb begin
      case (address[15:14])
         2'b00:   bank = 6'd0;
         2'b01:   bank = 6'd1;
         default: bank = slot_two_bank;
      endcase
      phys = {bank, address[13:0]} & rom_address_mask & RomWidthMask;
   end

   always_comb begin
      decode.bank_wr     = op && (address == cmbm_pkg::ADDR_BANK_REG);
      decode.axis_wr     = op && gb_mode && (address == cmbm_pkg::ADDR_PEN_AXIS);
      decode.sram_wr     = op && in_sram;
      decode.ram_wr      = op && in_ram;
      decode.src         = cmbm_pkg::SRC_IMM;
      decode.imm_data    = 8'h00;
      decode.rom_fetch   = 1'b0;
      decode.rom_address = 20'd0;
      if (!op) begin
         if (gb_mode && (address == cmbm_pkg::ADDR_PEN_STATUS)) begin
            decode.imm_data = {7'd0, !pen_pressed};
         end else if (gb_mode && (address == cmbm_pkg::ADDR_PEN_POS)) begin
            if (pen_off) begin
               decode.imm_data = 8'h00;
            end else if (pen_axis_select) begin
               decode.imm_data = px_adj[7:0];
            end else begin
               decode.imm_data = py_adj[7:0];
            end
         end else if (rom_hit) begin
            decode.rom_fetch   = 1'b1;
            decode.rom_address = phys;
         end else if (in_sram) begin
            decode.src = cmbm_pkg::SRC_SRAM;
         end else if (in_ram) begin
            decode.src = cmbm_pkg::SRC_RAM;
         end else begin
            decode.imm_data = 8'hFF;
         end
      end
   end

endmodule

// ===== tb/cmbm_bus_checker.sv =====
// Bus decoder checker: watches the request, response and csr channels, predicts each response
// and compares it field by field with the oldest prediction outstanding.
// Depends on cmbm_pkg.
module cmbm_bus_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_op,
   input  logic [15:0]       req_address,
   input  logic [7:0]        req_write_data,
   input  logic              req_pen_pressed,
   input  logic signed [9:0] req_pen_x,
   input  logic signed [9:0] req_pen_y,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [7:0]        rsp_read_data,
   input  logic              rsp_rom_fetch,
   input  logic [19:0]       rsp_rom_address,
   input  logic              rsp_sram_touched,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [20:0]       csr_data,
   output int                error_count,
   output int                responses_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] SRAM_BASE = 16'h8000;
   localparam logic [15:0] RAM_BASE  = 16'hC000;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        rom_fetch;
      logic [19:0] rom_address;
      logic        sram_touched;
   } bus_reply_type;

   logic          pen_board_on;
   logic [20:0]   rom_limit;
   logic [19:0]   rom_window;
   logic [5:0]    bank_sel;
   logic          pen_axis;
   logic          sram_dirty;
   logic [7:0]    cart_store [0:8191];
   logic [7:0]    work_store [0:1023];
   bus_reply_type replies_due [$];

   function automatic bus_reply_type decode_access(input logic is_write, input logic [15:0] a,
         input logic [7:0] d, input logic pressed, input logic signed [9:0] px,
         input logic signed [9:0] py);
      bus_reply_type r;
      logic [5:0]    bank;
      logic [19:0]   phys;
      int            x;
      int            y;
      r = '0;
      x = px;
      y = py;
      if (is_write) begin
         if (a == cmbm_pkg::ADDR_BANK_REG) bank_sel = d[5:0];
         if (pen_board_on && a == cmbm_pkg::ADDR_PEN_AXIS) pen_axis = d[0];
         if (a >= SRAM_BASE && a <= cmbm_pkg::ADDR_ROM_TOP) begin
            cart_store[a[12:0]] = d;
            sram_dirty = 1'b1;
         end
         if (a >= RAM_BASE) work_store[a[9:0]] = d;
      end else if (pen_board_on && a == cmbm_pkg::ADDR_PEN_STATUS) begin
         r.read_data = pressed ? 8'h00 : 8'h01;
      end else if (pen_board_on && a == cmbm_pkg::ADDR_PEN_POS) begin
         if (x < 2 || x > 254 || y < 0 || y > 192) r.read_data = 8'h00;
         else if (pen_axis) r.read_data = 8'(x - 2);
         else r.read_data = 8'(y + 28);
      end else if (a <= cmbm_pkg::ADDR_ROM_TOP && 21'(a) < rom_limit) begin
         case (a[15:14])
            2'd0: bank = 6'd0;
            2'd1: bank = 6'd1;
            default: bank = bank_sel;
         endcase
         phys = {bank, a[13:0]};
         r.rom_fetch = 1'b1;
         r.rom_address = phys & rom_window;
      end else if (a >= SRAM_BASE && a <= cmbm_pkg::ADDR_ROM_TOP) begin
         r.read_data = cart_store[a[12:0]];
      end else if (a >= RAM_BASE) begin
         r.read_data = work_store[a[9:0]];
      end else begin
         r.read_data = 8'hFF;
      end
      r.sram_touched = sram_dirty;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      bus_reply_type want;
      if (reset) begin
         pen_board_on = 1'b0;
         rom_limit = '0;
         rom_window = '0;
         bank_sel = cmbm_pkg::SLOT_TWO_RESET;
         pen_axis = 1'b0;
         sram_dirty = 1'b0;
         for (int i = 0; i < 8192; i++) cart_store[i] = '0;
         for (int i = 0; i < 1024; i++) work_store[i] = '0;
         replies_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cmbm_pkg::CSR_GB_MODE:   pen_board_on = csr_data[0];
               cmbm_pkg::CSR_ROM_COUNT: rom_limit = csr_data;
               cmbm_pkg::CSR_ROM_MASK:  rom_window = csr_data[19:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("response transaction with nothing outstanding");
               error_count++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data: expected %0h, got %0h", want.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_rom_fetch !== want.rom_fetch) begin
                  $error("rom_fetch: expected %0d, got %0d", want.rom_fetch, rsp_rom_fetch);
                  error_count++;
               end
               if (rsp_rom_address !== want.rom_address) begin
                  $error("rom_address: expected %0h, got %0h", want.rom_address,
                     rsp_rom_address);
                  error_count++;
               end
               if (rsp_sram_touched !== want.sram_touched) begin
                  $error("sram_touched: expected %0d, got %0d", want.sram_touched,
                     rsp_sram_touched);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(decode_access(req_op, req_address, req_write_data,
               req_pen_pressed, req_pen_x, req_pen_y));
      end
      responses_due <= replies_due.size();
   end

endmodule

// ===== tb/console_memory_map_with_bank_mapper_tb.sv =====
// Testbench top for the cartridge bus decoder: clock, reset, directed and random bus
// transactions, csr settings, idling on both sides, watchdog and verdict.
// Depends on cmbm_pkg, console_memory_map_with_bank_mapper and cmbm_bus_checker.
module console_memory_map_with_bank_mapper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam int   WATCHDOG_LIMIT = 50000;
   localparam int   ROM_MAX_BYTES  = 1048576;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_op = OP_READ;
   logic [15:0]       req_address = '0;
   logic [7:0]        req_write_data = '0;
   logic              req_pen_pressed = 1'b0;
   logic signed [9:0] req_pen_x = '0;
   logic signed [9:0] req_pen_y = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_read_data;
   logic              rsp_rom_fetch;
   logic [19:0]       rsp_rom_address;
   logic              rsp_sram_touched;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = cmbm_pkg::CSR_GB_MODE;
   logic [20:0]       csr_data = '0;

   int error_count;
   int responses_due;
   int send_idle = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int accesses_sent = 0;
   int settings_used = 0;

   always #4 clock = ~clock;

   console_memory_map_with_bank_mapper u_top (.*);

   cmbm_bus_checker u_checker (.*);

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays high after acceptance
   task automatic bus_access(input logic op, input logic [15:0] a, input logic [7:0] d,
         input logic pressed, input logic signed [9:0] px, input logic signed [9:0] py);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= a;
      req_write_data <= d;
      req_pen_pressed <= pressed;
      req_pen_x <= px;
      req_pen_y <= py;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      accesses_sent++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [20:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic gb, input logic [20:0] count, input logic [19:0] mask);
      csr_write(cmbm_pkg::CSR_GB_MODE, 21'(gb));
      csr_write(cmbm_pkg::CSR_ROM_COUNT, count);
      csr_write(cmbm_pkg::CSR_ROM_MASK, 21'(mask));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // hold off the sender until every outstanding response has returned
   task automatic drain;
      req_valid <= 1'b0;
      while (responses_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_config(input int pick);
      logic [20:0] count;
      logic [19:0] mask;
      case ($urandom_range(4))
         0: count = '0;
         1: count = 21'(ROM_MAX_BYTES);
         2: count = 21'($urandom_range(ROM_MAX_BYTES));
         3: count = 21'h08000;
         default: count = 21'($urandom_range(21'h0C000));
      endcase
      case ($urandom_range(2))
         0: mask = '0;
         1: mask = 20'hFFFFF;
         default: mask = 20'((32'd1 << $urandom_range(14, 20)) - 1);
      endcase
      if (pick == 0) set_config(1'b1, 21'(ROM_MAX_BYTES), 20'hFFFFF);
      else if (pick == 1) set_config(1'b0, '0, '0);
      else set_config(1'($urandom), count, mask);
   endtask

   task automatic random_access;
      logic [15:0]       a;
      logic signed [9:0] px;
      logic signed [9:0] py;
      case ($urandom_range(9))
         0: a = cmbm_pkg::ADDR_BANK_REG;
         1: a = cmbm_pkg::ADDR_PEN_AXIS;
         2: a = cmbm_pkg::ADDR_PEN_STATUS;
         3: a = cmbm_pkg::ADDR_PEN_POS;
         4: a = 16'h8000 + 16'($urandom_range(16'h3FFF));
         5, 6: a = 16'hC000 + 16'($urandom_range(16'h3FFF));
         7: a = 16'($urandom_range(cmbm_pkg::ADDR_ROM_TOP));
         default: a = 16'($urandom);
      endcase
      if ($urandom_range(1)) begin
         px = 10'(int'($urandom_range(264)) - 4);
         py = 10'(int'($urandom_range(200)) - 4);
      end else begin
         px = 10'($urandom);
         py = 10'($urandom);
      end
      bus_access($urandom_range(1) ? OP_WRITE : OP_READ, a, 8'($urandom), 1'($urandom),
         px, py);
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 23;
      stall_pct = 77;

      // pen board on, 48 KiB of ROM
      set_config(1'b1, 21'h0C000, 20'hFFFFF);
      bus_access(OP_READ, 16'h0000, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, 16'h7FFF, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_BANK_REG, 8'hC5, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, 16'h8001, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_ROM_TOP, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_BANK_REG, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, 16'hC3FF, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_STATUS, 8'h00, 1'b1, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_STATUS, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd2, 10'sd0);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_PEN_AXIS, 8'hFF, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b1, 10'sd254, 10'sd192);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd255, 10'sd100);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd1, 10'sd100);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd100, -10'sd1);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd100, 10'sd193);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, -10'sd512, 10'sd511);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_PEN_AXIS, 8'h02, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_PEN_STATUS, 8'hAA, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_WRITE, 16'h1234, 8'h55, 1'b0, 10'sd0, 10'sd0);

      // no pen board, no ROM: SRAM mirror, an unmapped read, ignored axis write
      drain;
      set_config(1'b0, '0, '0);
      bus_access(OP_READ, cmbm_pkg::ADDR_PEN_POS, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, 16'h0000, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_PEN_AXIS, 8'h01, 1'b0, 10'sd0, 10'sd0);

      // largest ROM, highest bank
      drain;
      set_config(1'b1, 21'(ROM_MAX_BYTES), 20'hFFFFF);
      bus_access(OP_WRITE, cmbm_pkg::ADDR_BANK_REG, 8'hFF, 1'b1, 10'sd511, 10'sd511);
      bus_access(OP_READ, cmbm_pkg::ADDR_ROM_TOP, 8'h00, 1'b0, 10'sd0, 10'sd0);
      bus_access(OP_READ, 16'hC000, 8'h00, 1'b0, 10'sd0, 10'sd0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
         stall_pct = (phase == 0) ? 77 : (phase == 1) ? 23 : 0;
         for (int block = 0; block < 3; block++) begin
            drain;
            random_config(phase * 3 + block);
            repeat (72) random_access();
         end
      end

      drain;
      repeat (10) @(negedge clock);
      $display("Covered %0d bus transactions over %0d csr settings: pen, bank, ROM, SRAM,",
         accesses_sent, settings_used);
      $display("RAM and unmapped decodes, with sender and receiver gaps and a gapless stretch.");
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
